// File: sv/obme_pkg.sv
// Shared types, constants and helpers for the order book matching engine.
package obme_pkg;

    localparam int PRICE_W = 31;
    localparam int QTY_W   = 31;
    localparam int ID_W    = 24;
    localparam int SUM_W   = QTY_W + 1;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 88;

    localparam logic [ST_W-1:0] ST_RESTED = 2'd0;
    localparam logic [ST_W-1:0] ST_FILLED = 2'd1;
    localparam logic [ST_W-1:0] ST_KILLED = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int OP_SELL_BIT = 0;
    localparam int OP_FOK_BIT  = 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_MATCH,
        S_KILL,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic sum_step;
        logic emit_trade;
        logic emit_status;
        logic kill;
    } t_ctrl_cmd;

    typedef struct packed {
        logic sum_more;
        logic sum_ok;
        logic match_go;
        logic out_free;
    } t_ctrl_sts;

    typedef struct packed {
        logic drop;
        logic wr_front;
        logic insert;
    } t_side_cmd;

    function automatic logic ahead(input logic is_bid,
                                   input logic [PRICE_W-1:0] pa, input logic [ID_W-1:0] ia,
                                   input logic [PRICE_W-1:0] pb, input logic [ID_W-1:0] ib);
        logic r;
        if (pa != pb) begin
            r = is_bid ? (pa > pb) : (pa < pb);
        end else begin
            r = ia < ib;
        end
        return r;
    endfunction

endpackage

// File: sv/obme_side.sv
// One side of the book: a sorted row of entry cells with front access and insert.
module obme_side #(
    parameter int   DEPTH  = 32,
    parameter logic IS_BID = 1'b1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  obme_pkg::t_side_cmd           i_cmd,
    input  logic [obme_pkg::QTY_W-1:0]    i_front_amt,
    input  logic [obme_pkg::PRICE_W-1:0]  i_ins_price,
    input  logic [obme_pkg::QTY_W-1:0]    i_ins_amt,
    input  logic [obme_pkg::ID_W-1:0]     i_ins_id,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_idx,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    output logic [obme_pkg::PRICE_W-1:0]  o_front_price,
    output logic [obme_pkg::QTY_W-1:0]    o_front_amt,
    output logic [obme_pkg::ID_W-1:0]     o_front_id,
    output logic [obme_pkg::PRICE_W-1:0]  o_rd_price,
    output logic [obme_pkg::QTY_W-1:0]    o_rd_amt
);
    import obme_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [PRICE_W-1:0] r_price [DEPTH];
    logic [QTY_W-1:0]   r_amt   [DEPTH];
    logic [ID_W-1:0]    r_id    [DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [DEPTH-1:0]   keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.drop) begin
            r_count <= r_count - CNT_W'(1);
        end else if (i_cmd.insert) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign keep[i] = (CNT_W'(i) < r_count)
                       && !ahead(IS_BID, i_ins_price, i_ins_id, r_price[i], r_id[i]);

        always_ff @(posedge i_clk) begin
            if (i_cmd.drop) begin
                if (i < DEPTH-1) begin
                    r_price[i] <= r_price[(i < DEPTH-1) ? i+1 : i];
                    r_amt[i]   <= r_amt[(i < DEPTH-1) ? i+1 : i];
                    r_id[i]    <= r_id[(i < DEPTH-1) ? i+1 : i];
                end
            end else if (i_cmd.wr_front && i == 0) begin
                r_amt[i] <= i_front_amt;
            end else if (i_cmd.insert && !keep[i]) begin
                if (i == 0 || keep[(i > 0) ? i-1 : 0]) begin
                    r_price[i] <= i_ins_price;
                    r_amt[i]   <= i_ins_amt;
                    r_id[i]    <= i_ins_id;
                end else begin
                    r_price[i] <= r_price[(i > 0) ? i-1 : 0];
                    r_amt[i]   <= r_amt[(i > 0) ? i-1 : 0];
                    r_id[i]    <= r_id[(i > 0) ? i-1 : 0];
                end
            end
        end
    end

    assign o_count       = r_count;
    assign o_front_price = r_price[0];
    assign o_front_amt   = r_amt[0];
    assign o_front_id    = r_id[0];
    assign o_rd_price    = r_price[i_rd_idx];
    assign o_rd_amt      = r_amt[i_rd_idx];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("book side count beyond depth");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> r_count < CNT_W'(DEPTH))
        else $error("insert into full book side");

endmodule

// File: sv/obme_dpath.sv
// Datapath: order registers, availability sum, trade arithmetic, both book sides, output register.
module obme_dpath #(
    parameter int DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  obme_pkg::t_ctrl_cmd                i_cmd,
    output obme_pkg::t_ctrl_sts                o_sts,
    input  logic [obme_pkg::OP_W-1:0]          i_op,
    input  logic [obme_pkg::IN_DATA_W-1:0]     i_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [obme_pkg::OUT_DATA_W-1:0]    o_out_data,
    output logic                               o_out_kind,
    output logic                               o_out_last
);
    import obme_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int IDX_W = $clog2(DEPTH);

    logic               r_buyer;
    logic               r_fok;
    logic [PRICE_W-1:0] r_price;
    logic [QTY_W-1:0]   r_qty;
    logic [ID_W-1:0]    r_id;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_idx;

    logic               r_ovalid;
    logic               r_okind;
    logic [ID_W-1:0]    r_osell;
    logic [ID_W-1:0]    r_obuy;
    logic [QTY_W-1:0]   r_otraded;
    logic [ST_W-1:0]    r_ost;
    logic               r_olast;

    t_side_cmd          bid_cmd, ask_cmd, own_cmd, opp_cmd;
    logic [CNT_W-1:0]   bid_cnt, ask_cnt, opp_cnt, own_cnt;
    logic [PRICE_W-1:0] bid_fp, ask_fp, opp_fp, bid_rp, ask_rp, opp_rp;
    logic [QTY_W-1:0]   bid_fa, ask_fa, opp_fa, bid_ra, ask_ra, opp_ra;
    logic [ID_W-1:0]    bid_fi, ask_fi, opp_fi;
    logic               front_acc, rd_acc, out_free, own_room;
    logic [QTY_W-1:0]   take, rem;
    logic [ST_W-1:0]    fin_st;

    assign opp_cnt = r_buyer ? ask_cnt : bid_cnt;
    assign own_cnt = r_buyer ? bid_cnt : ask_cnt;
    assign opp_fp  = r_buyer ? ask_fp  : bid_fp;
    assign opp_fa  = r_buyer ? ask_fa  : bid_fa;
    assign opp_fi  = r_buyer ? ask_fi  : bid_fi;
    assign opp_rp  = r_buyer ? ask_rp  : bid_rp;
    assign opp_ra  = r_buyer ? ask_ra  : bid_ra;

    assign front_acc = r_buyer ? (opp_fp <= r_price) : (opp_fp >= r_price);
    assign rd_acc    = r_buyer ? (opp_rp <= r_price) : (opp_rp >= r_price);
    assign take      = (r_qty < opp_fa) ? r_qty : opp_fa;
    assign rem       = opp_fa - take;
    assign out_free  = !r_ovalid || i_out_ready;
    assign own_room  = own_cnt < CNT_W'(DEPTH);

    always_comb begin
        if (r_qty == '0 || r_fok) begin
            fin_st = ST_FILLED;
        end else if (own_room) begin
            fin_st = ST_RESTED;
        end else begin
            fin_st = ST_FULL;
        end
    end

    assign o_sts.sum_more = (r_idx < opp_cnt) && rd_acc && (r_sum < {1'b0, r_qty});
    assign o_sts.sum_ok   = r_sum >= {1'b0, r_qty};
    assign o_sts.match_go = (r_qty != '0) && (opp_cnt != '0) && front_acc;
    assign o_sts.out_free = out_free;

    assign opp_cmd.drop     = i_cmd.emit_trade && (rem == '0);
    assign opp_cmd.wr_front = i_cmd.emit_trade && (rem != '0);
    assign opp_cmd.insert   = 1'b0;
    assign own_cmd.drop     = 1'b0;
    assign own_cmd.wr_front = 1'b0;
    assign own_cmd.insert   = i_cmd.emit_status && !i_cmd.kill && (fin_st == ST_RESTED);
    assign bid_cmd = r_buyer ? own_cmd : opp_cmd;
    assign ask_cmd = r_buyer ? opp_cmd : own_cmd;

    obme_side #(.DEPTH(DEPTH), .IS_BID(1'b1)) u_bid (
        .i_clk, .i_rst_n,
        .i_cmd(bid_cmd), .i_front_amt(rem),
        .i_ins_price(r_price), .i_ins_amt(r_qty), .i_ins_id(r_id),
        .i_rd_idx(r_idx[IDX_W-1:0]),
        .o_count(bid_cnt), .o_front_price(bid_fp), .o_front_amt(bid_fa),
        .o_front_id(bid_fi), .o_rd_price(bid_rp), .o_rd_amt(bid_ra)
    );

    obme_side #(.DEPTH(DEPTH), .IS_BID(1'b0)) u_ask (
        .i_clk, .i_rst_n,
        .i_cmd(ask_cmd), .i_front_amt(rem),
        .i_ins_price(r_price), .i_ins_amt(r_qty), .i_ins_id(r_id),
        .i_rd_idx(r_idx[IDX_W-1:0]),
        .o_count(ask_cnt), .o_front_price(ask_fp), .o_front_amt(ask_fa),
        .o_front_id(ask_fi), .o_rd_price(ask_rp), .o_rd_amt(ask_ra)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_buyer <= !i_op[OP_SELL_BIT];
            r_fok   <= i_op[OP_FOK_BIT];
            r_price <= i_data[PRICE_W-1:0];
            r_qty   <= i_data[PRICE_W+QTY_W-1:PRICE_W];
            r_id    <= i_data[PRICE_W+QTY_W+ID_W-1:PRICE_W+QTY_W];
            r_sum   <= '0;
            r_idx   <= '0;
        end else if (i_cmd.sum_step) begin
            r_sum <= r_sum + SUM_W'(opp_ra);
            r_idx <= r_idx + CNT_W'(1);
        end else if (i_cmd.emit_trade) begin
            r_qty <= r_qty - take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_trade || i_cmd.emit_status) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_trade) begin
            r_okind   <= KIND_TRADE;
            r_osell   <= r_buyer ? opp_fi : r_id;
            r_obuy    <= r_buyer ? r_id : opp_fi;
            r_otraded <= take;
            r_ost     <= ST_RESTED;
            r_olast   <= 1'b0;
        end else if (i_cmd.emit_status) begin
            r_okind   <= KIND_STATUS;
            r_osell   <= r_id;
            r_obuy    <= '0;
            r_otraded <= '0;
            r_ost     <= i_cmd.kill ? ST_KILLED : fin_st;
            r_olast   <= 1'b1;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_kind  = r_okind;
    assign o_out_last  = r_olast;
    assign o_out_data  = {7'd0, r_ost, r_otraded, r_obuy, r_osell};

    a_trade_crosses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_trade |-> (take != '0) && (opp_cnt != '0))
        else $error("trade emitted without a crossing entry");

endmodule

// File: sv/obme_ctrl.sv
// Controller: sequences load, availability scan, matching and the final status record.
module obme_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_fok,
    output logic                o_in_ready,
    input  obme_pkg::t_ctrl_sts i_sts,
    output obme_pkg::t_ctrl_cmd o_cmd
);
    import obme_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_in_fok ? S_SUM : S_MATCH;
                end
            end
            S_SUM: begin
                if (i_sts.sum_more) begin
                    o_cmd.sum_step = 1'b1;
                end else begin
                    n_state = i_sts.sum_ok ? S_MATCH : S_KILL;
                end
            end
            S_MATCH: begin
                if (!i_sts.match_go) begin
                    n_state = S_FINISH;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_trade = 1'b1;
                end
            end
            S_KILL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    o_cmd.kill        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_trade || o_cmd.emit_status) |-> i_sts.out_free)
        else $error("record emitted while output register busy");

endmodule

// File: sv/order_book_matching_engine.sv
// Top level of the price-time priority order book matching engine.
// One order enters per transfer on the s_axis channel: tuser carries the opcode
// (bit 0 sell, bit 1 fill-or-kill), tdata carries price, quantity and id.
// Results leave on the m_axis channel: one transfer per trade, then one status
// transfer with tlast high; tuser is the record kind (0 trade, 1 status).
// Per order: the engine takes it, emits one record per trade, leaves the match
// loop and emits the status record. A fill-or-kill order first scans resting
// entries for the availability check (stops once the quantity is covered) and
// settles the check; a killed order then emits only its status record. The match
// loop consumes one resting entry per cycle while the output register is free.
// The next order is taken as soon as the status record sits in the output
// register. When the receiver stalls, the output register holds its record and
// the engine waits before producing the next one. Reset empties both book sides
// and the output register; entry contents need no clearing.
module order_book_matching_engine #(
    parameter int BOOK_DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [obme_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // price, quantity, order_id
    input  logic [obme_pkg::OP_W-1:0]          s_axis_tuser,  // opcode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [obme_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // sell_id, buy_id, traded, status
    output logic                               m_axis_tuser,  // record_kind
    output logic                               m_axis_tlast
);
    import obme_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    obme_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid),
        .i_in_fok(s_axis_tuser[OP_FOK_BIT]),
        .o_in_ready(s_axis_tready),
        .i_sts(sts),
        .o_cmd(cmd)
    );

    obme_dpath #(.DEPTH(BOOK_DEPTH)) u_dpath (
        .i_clk, .i_rst_n,
        .i_cmd(cmd),
        .o_sts(sts),
        .i_op(s_axis_tuser),
        .i_data(s_axis_tdata),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_data(m_axis_tdata),
        .o_out_kind(m_axis_tuser),
        .o_out_last(m_axis_tlast)
    );

endmodule
